>>> rtl/core/sieau_pkg.sv
// shared types, command codes and find helpers for the integer extended alu
package sieau_pkg;

   localparam int unsigned CMD_W  = 4;
   localparam int unsigned DATA_W = 64;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned POS_W  = 5;

   localparam logic [CMD_W-1:0] CMD_SABS     = 4'd0;
   localparam logic [CMD_W-1:0] CMD_SSIGN    = 4'd1;
   localparam logic [CMD_W-1:0] CMD_UMIN     = 4'd2;
   localparam logic [CMD_W-1:0] CMD_UMAX     = 4'd3;
   localparam logic [CMD_W-1:0] CMD_SMIN     = 4'd4;
   localparam logic [CMD_W-1:0] CMD_SMAX     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_SCLAMP   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_UCLAMP   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_FINDLSB  = 4'd8;
   localparam logic [CMD_W-1:0] CMD_FINDUMSB = 4'd9;
   localparam logic [CMD_W-1:0] CMD_FINDSMSB = 4'd10;

   localparam logic [DATA_W-1:0] LOW_WORD_MASK = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic              is_wide;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
      logic [DATA_W-1:0] operand_c;
   } op_type;

   // lowest set bit position, x assumed nonzero
   function automatic logic [POS_W-1:0] lsb_pos(input logic [WORD_W-1:0] x);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (x[i]) pos = POS_W'(i);
      end
      return pos;
   endfunction

   // highest set bit position, x assumed nonzero
   function automatic logic [POS_W-1:0] msb_pos(input logic [WORD_W-1:0] x);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (x[i]) pos = POS_W'(i);
      end
      return pos;
   endfunction

endpackage

>>> rtl/core/sieau_core.sv
// combinational datapath: abs, sign, min/max, clamp and bit finds on one beat
module sieau_core (
   input  sieau_pkg::op_type                 op,
   output logic [sieau_pkg::DATA_W-1:0]      result
);

   logic [sieau_pkg::DATA_W-1:0] a, b, c;
   logic [sieau_pkg::DATA_W-1:0] sa, sb, sc;
   logic [sieau_pkg::DATA_W-1:0] neg_a;
   logic [sieau_pkg::DATA_W-1:0] all_ones;
   logic [sieau_pkg::WORD_W-1:0] lo;
   logic [sieau_pkg::WORD_W-1:0] smsb_src;
   logic                         a_neg;
   logic                         s_a_lt_b, s_a_gt_b, s_a_gt_c;
   logic                         u_a_lt_b, u_a_gt_b, u_a_gt_c;
   logic [sieau_pkg::DATA_W-1:0] lsb_res, umsb_res, smsb_res;

   always_comb begin
      a  = op.is_wide ? op.operand_a : (op.operand_a & sieau_pkg::LOW_WORD_MASK);
      b  = op.is_wide ? op.operand_b : (op.operand_b & sieau_pkg::LOW_WORD_MASK);
      c  = op.is_wide ? op.operand_c : (op.operand_c & sieau_pkg::LOW_WORD_MASK);
      sa = op.is_wide ? op.operand_a : {{32{op.operand_a[31]}}, op.operand_a[31:0]};
      sb = op.is_wide ? op.operand_b : {{32{op.operand_b[31]}}, op.operand_b[31:0]};
      sc = op.is_wide ? op.operand_c : {{32{op.operand_c[31]}}, op.operand_c[31:0]};
      a_neg    = sa[sieau_pkg::DATA_W-1];
      neg_a    = '0 - a;
      if (!op.is_wide) neg_a = neg_a & sieau_pkg::LOW_WORD_MASK;
      all_ones = op.is_wide ? '1 : sieau_pkg::LOW_WORD_MASK;

      s_a_lt_b = $signed(sa) < $signed(sb);
      s_a_gt_b = $signed(sa) > $signed(sb);
      s_a_gt_c = $signed(sa) > $signed(sc);
      u_a_lt_b = a < b;
      u_a_gt_b = a > b;
      u_a_gt_c = a > c;

      lo       = op.operand_a[sieau_pkg::WORD_W-1:0];
      smsb_src = lo[sieau_pkg::WORD_W-1] ? ~lo : lo;

      lsb_res  = (lo == '0) ? sieau_pkg::LOW_WORD_MASK
                            : sieau_pkg::DATA_W'(sieau_pkg::lsb_pos(lo));
      umsb_res = (lo == '0) ? sieau_pkg::LOW_WORD_MASK
                            : sieau_pkg::DATA_W'(sieau_pkg::msb_pos(lo));
      smsb_res = (smsb_src == '0) ? sieau_pkg::LOW_WORD_MASK
                                  : sieau_pkg::DATA_W'(sieau_pkg::msb_pos(smsb_src));

      case (op.command)
         sieau_pkg::CMD_SABS:     result = a_neg ? neg_a : a;
         sieau_pkg::CMD_SSIGN:    result = a_neg ? all_ones
                                         : ((a != '0) ? sieau_pkg::DATA_W'(1) : '0);
         sieau_pkg::CMD_UMIN:     result = u_a_lt_b ? a : b;
         sieau_pkg::CMD_UMAX:     result = u_a_gt_b ? a : b;
         sieau_pkg::CMD_SMIN:     result = s_a_lt_b ? a : b;
         sieau_pkg::CMD_SMAX:     result = s_a_gt_b ? a : b;
         sieau_pkg::CMD_SCLAMP:   result = s_a_lt_b ? b : (s_a_gt_c ? c : a);
         sieau_pkg::CMD_UCLAMP:   result = u_a_lt_b ? b : (u_a_gt_c ? c : a);
         sieau_pkg::CMD_FINDLSB:  result = lsb_res;
         sieau_pkg::CMD_FINDUMSB: result = umsb_res;
         sieau_pkg::CMD_FINDSMSB: result = smsb_res;
         default:                 result = '0;
      endcase
   end

endmodule

>>> rtl/core/shader_integer_extended_alu_unit.sv
// top level of the scalar integer extended alu: input register, datapath, result register
// an accepted request beat is held in the input register, and its result then in the result register
// throughput: one beat per cycle unless a response stalls, set by the single-pass datapath between the registers
// a stalled response holds the result register; the input register holds at most one beat behind it
// reset clears both valid flags; payload registers are not reset
module shader_integer_extended_alu_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sieau_pkg::CMD_W-1:0]       req_command,
   input  logic                              req_is_wide,
   input  logic [sieau_pkg::DATA_W-1:0]      req_operand_a,
   input  logic [sieau_pkg::DATA_W-1:0]      req_operand_b,
   input  logic [sieau_pkg::DATA_W-1:0]      req_operand_c,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sieau_pkg::DATA_W-1:0]      rsp_result
);

   logic                         op_valid_ff;
   sieau_pkg::op_type            op_ff;
   sieau_pkg::op_type            op_in;
   logic                         rsp_valid_ff;
   logic [sieau_pkg::DATA_W-1:0] rsp_result_ff;
   logic [sieau_pkg::DATA_W-1:0] rsp_result_in;
   logic                         advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = op_valid_ff && !advance;

   always_comb begin
      op_in.command   = req_command;
      op_in.is_wide   = req_is_wide;
      op_in.operand_a = req_operand_a;
      op_in.operand_b = req_operand_b;
      op_in.operand_c = req_operand_c;
   end

   sieau_core u_core (
      .op     (op_ff),
      .result (rsp_result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) op_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= op_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) op_ff <= op_in;
      if (advance && op_valid_ff) rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // a stall toward the requester only while the input register is full
   assert property (@(posedge clock) req_stall |-> op_valid_ff)
      else $error("req_stall without a held beat");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> op_valid_ff)
      else $error("accepted beat lost at input register");

   assert property (@(posedge clock) disable iff (reset)
      (op_valid_ff && advance) |=> rsp_valid_ff)
      else $error("computed beat did not reach result register");

   assert property (@(posedge clock) reset |=> (!op_valid_ff && !rsp_valid_ff))
      else $error("valid flags not cleared by reset");

endmodule
